### design/wcm_pkg.sv
// ----------------------------------------------------------------------------
// wcm_pkg
// Shared types, constants and tables for the windowed circular mean block.
// ----------------------------------------------------------------------------
package wcm_pkg;

	localparam int ANGLE_BITS         = 16;
	localparam int DEF_WINDOW_DEPTH   = 64;
	localparam int FILL_W             = 7;
	localparam int THR_W              = 15;
	localparam int SUM_W              = 23;
	localparam int CW                 = 34;
	localparam int ZW                 = 32;
	localparam int CORDIC_STEPS       = 24;
	localparam int STEP_W             = 5;
	localparam int VEC_SHIFT          = 6;
	localparam int MEAN_SHIFT         = ZW - ANGLE_BITS;
	localparam int Q15_MAX            = 32767;
	localparam int Q15_MIN            = -32768;
	localparam int Q15_ROUND          = 16384;

	localparam logic signed [CW-1:0] CORDIC_START_X = CW'(652032874);
	localparam logic [ZW-1:0]        HALF_TURN      = 32'h8000_0000;
	localparam logic [ZW-1:0]        MEAN_ROUND     = ZW'(1) << (MEAN_SHIFT - 1);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_JUMP_THRESHOLD = 2'd1;

	localparam logic [FILL_W-1:0] WINDOW_SIZE_RESET    = 7'd8;
	localparam logic [THR_W-1:0]  JUMP_THRESHOLD_RESET = 15'd1565;

	typedef struct packed {
		logic                         kind;
		logic signed [ANGLE_BITS-1:0] angle;
	} in_item_t;

	typedef struct packed {
		logic signed [ANGLE_BITS-1:0] mean_angle;
		logic [FILL_W-1:0]            fill_count;
		logic                         window_full;
		logic                         jump_cleared;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_JUMP,
		ST_OLD_GO,
		ST_OLD_WAIT,
		ST_OLD_ACC,
		ST_NEW_GO,
		ST_NEW_WAIT,
		ST_NEW_ACC,
		ST_VEC_GO,
		ST_VEC_WAIT,
		ST_OUT
	} state_t;

	typedef enum logic {
		MODE_ROTATE,
		MODE_VECTOR
	} cordic_mode_t;

	typedef struct packed {
		logic accept;
		logic jump_eval;
		logic rot_start;
		logic rot_old;
		logic rot_take;
		logic acc_sub;
		logic commit;
		logic acc_add;
		logic vec_start;
		logic mean_zero;
		logic mean_take;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic evict;
		logic sums_zero;
		logic cordic_done;
	} dp_status_t;

	function automatic logic [ZW-1:0] atan_at(input logic [STEP_W-1:0] idx);
		logic [ZW-1:0] r;
		case (idx)
			5'd0:    r = 32'h2000_0000;
			5'd1:    r = 32'h12E4_051E;
			5'd2:    r = 32'h09FB_385B;
			5'd3:    r = 32'h0511_11D4;
			5'd4:    r = 32'h028B_0D43;
			5'd5:    r = 32'h0145_D7E1;
			5'd6:    r = 32'h00A2_F61E;
			5'd7:    r = 32'h0051_7C55;
			5'd8:    r = 32'h0028_BE53;
			5'd9:    r = 32'h0014_5F2F;
			5'd10:   r = 32'h000A_2F98;
			5'd11:   r = 32'h0005_17CC;
			5'd12:   r = 32'h0002_8BE6;
			5'd13:   r = 32'h0001_45F3;
			5'd14:   r = 32'h0000_A2FA;
			5'd15:   r = 32'h0000_517D;
			5'd16:   r = 32'h0000_28BE;
			5'd17:   r = 32'h0000_145F;
			5'd18:   r = 32'h0000_0A30;
			5'd19:   r = 32'h0000_0518;
			5'd20:   r = 32'h0000_028C;
			5'd21:   r = 32'h0000_0146;
			5'd22:   r = 32'h0000_00A3;
			5'd23:   r = 32'h0000_0051;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

### design/wcm_cordic.sv
// ----------------------------------------------------------------------------
// wcm_cordic
// Iterative CORDIC, one micro-rotation per cycle, rotation or vectoring mode.
// ----------------------------------------------------------------------------
module wcm_cordic (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  wcm_pkg::cordic_mode_t         mode,
	input  logic signed [wcm_pkg::CW-1:0] x0,
	input  logic signed [wcm_pkg::CW-1:0] y0,
	input  logic [wcm_pkg::ZW-1:0]        z0,
	output logic                          done,
	output logic signed [wcm_pkg::CW-1:0] x,
	output logic signed [wcm_pkg::CW-1:0] y,
	output logic [wcm_pkg::ZW-1:0]        z
);
	import wcm_pkg::*;

	logic signed [CW-1:0] x_q, y_q, dx, dy, x_d, y_d;
	logic [ZW-1:0]        z_q, z_d, at;
	logic [STEP_W-1:0]    step_q;
	logic                 run_q, done_q, pos;
	cordic_mode_t         mode_q;

	always_comb begin
		dx  = y_q >>> step_q;
		dy  = x_q >>> step_q;
		at  = atan_at(step_q);
		pos = (mode_q == MODE_ROTATE) ? !z_q[ZW-1] : y_q[CW-1];
		if (pos) begin
			x_d = x_q - dx;
			y_d = y_q + dy;
			z_d = z_q - at;
		end else begin
			x_d = x_q + dx;
			y_d = y_q - dy;
			z_d = z_q + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x0;
			y_q    <= y0;
			z_q    <= z0;
			mode_q <= mode;
		end else if (run_q) begin
			x_q <= x_d;
			y_q <= y_d;
			z_q <= z_d;
		end
	end

	assign done = done_q;
	assign x    = x_q;
	assign y    = y_q;
	assign z    = z_q;

endmodule

### design/wcm_datapath.sv
// ----------------------------------------------------------------------------
// wcm_datapath
// Sample ring, running sine and cosine sums, jump check, configuration
// registers, shared CORDIC and the result register.
// ----------------------------------------------------------------------------
module wcm_datapath #(
	parameter int WINDOW_DEPTH = wcm_pkg::DEF_WINDOW_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  wcm_pkg::in_item_t                in_data,
	input  logic                             cfg_valid,
	input  logic [wcm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wcm_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wcm_pkg::ctrl_cmd_t               cmd,
	output wcm_pkg::dp_status_t              status,
	output wcm_pkg::out_item_t               out_data
);
	import wcm_pkg::*;

	localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam logic [8:0] DEPTH9 = 9'(WINDOW_DEPTH);

	logic [FILL_W-1:0]           ws_q;
	logic [THR_W-1:0]            thr_q;
	logic [IDX_W-1:0]            wi_q, wi_next, old_idx;
	logic [FILL_W-1:0]           held_q;
	logic signed [SUM_W-1:0]     ss_q, cs_q;
	logic [ANGLE_BITS-1:0]       prev_q, angle_q, rd_q, rot_src;
	logic                        prev_valid_q, jumped_q, flip_q;
	logic signed [15:0]          sin_q, cos_q;
	logic [ANGLE_BITS-1:0]       mean_q;
	logic [ANGLE_BITS-1:0]       ring_q [WINDOW_DEPTH];
	out_item_t                   out_q;

	logic [ANGLE_BITS-1:0]       diff;
	logic [ANGLE_BITS:0]         mag;
	logic                        jump, cfg_hit, clear_win, full, rot_flip;
	logic [8:0]                  eff;
	logic [9:0]                  old_diff, old_wrap;
	logic [ZW-1:0]               ang32, rot_z0, vec_z0, zr;
	logic signed [SUM_W:0]       vx, vy;
	logic signed [CW-1:0]        vx_ext, vy_ext;
	logic signed [CW-1:0]        c_x0, c_y0, c_x, c_y;
	logic [ZW-1:0]               c_z0, c_z;
	logic                        c_start, c_done;
	cordic_mode_t                c_mode;

	function automatic logic signed [15:0] to_q15(input logic signed [CW-1:0] v,
			input logic neg);
		logic signed [CW-1:0] w;
		logic signed [CW-1:0] t;
		logic signed [CW-16:0] q;
		logic signed [15:0] r;
		w = neg ? -v : v;
		t = w + CW'(Q15_ROUND);
		q = signed'(t[CW-1:15]);
		if (q > (CW-15)'(Q15_MAX))
			r = 16'sh7fff;
		else if (q < (CW-15)'(Q15_MIN))
			r = 16'sh8000;
		else
			r = q[15:0];
		return r;
	endfunction

	// jump check and window bookkeeping
	always_comb begin
		diff      = angle_q - prev_q;
		mag       = diff[ANGLE_BITS-1] ? ((ANGLE_BITS+1)'(1) << ANGLE_BITS) - {1'b0, diff}
		                               : {1'b0, diff};
		jump      = prev_valid_q && (mag > (ANGLE_BITS+1)'(thr_q));
		eff       = (ws_q == '0) ? 9'd1 : ((9'(ws_q) > DEPTH9) ? DEPTH9 : 9'(ws_q));
		full      = 9'(held_q) >= eff;
		cfg_hit   = cfg_valid && (cfg_index == REG_WINDOW_SIZE ||
		                          cfg_index == REG_JUMP_THRESHOLD);
		clear_win = cfg_hit || (cmd.accept && in_data.kind) || (cmd.jump_eval && jump);
		old_diff  = 10'(wi_q) - 10'(held_q);
		old_wrap  = old_diff[9] ? old_diff + 10'(WINDOW_DEPTH) : old_diff;
		old_idx   = old_wrap[IDX_W-1:0];
		wi_next   = (wi_q == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : wi_q + 1'b1;
	end

	// cordic operand selection
	always_comb begin
		rot_src  = cmd.rot_old ? rd_q : angle_q;
		ang32    = {rot_src, {(ZW-ANGLE_BITS){1'b0}}};
		rot_flip = ang32[ZW-1] ^ ang32[ZW-2];
		rot_z0   = {ang32[ZW-1] ^ rot_flip, ang32[ZW-2:0]};
		vx       = cs_q[SUM_W-1] ? -(SUM_W+1)'(cs_q) : (SUM_W+1)'(cs_q);
		vy       = cs_q[SUM_W-1] ? -(SUM_W+1)'(ss_q) : (SUM_W+1)'(ss_q);
		vx_ext   = {{(CW-SUM_W-1){vx[SUM_W]}}, vx} <<< VEC_SHIFT;
		vy_ext   = {{(CW-SUM_W-1){vy[SUM_W]}}, vy} <<< VEC_SHIFT;
		vec_z0   = cs_q[SUM_W-1] ? HALF_TURN : '0;
		c_start  = cmd.rot_start || cmd.vec_start;
		c_mode   = cmd.vec_start ? MODE_VECTOR : MODE_ROTATE;
		c_x0     = cmd.vec_start ? vx_ext : CORDIC_START_X;
		c_y0     = cmd.vec_start ? vy_ext : '0;
		c_z0     = cmd.vec_start ? vec_z0 : rot_z0;
		zr       = c_z + MEAN_ROUND;
	end

	wcm_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (c_start),
		.mode   (c_mode),
		.x0     (c_x0),
		.y0     (c_y0),
		.z0     (c_z0),
		.done   (c_done),
		.x      (c_x),
		.y      (c_y),
		.z      (c_z)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q         <= WINDOW_SIZE_RESET;
			thr_q        <= JUMP_THRESHOLD_RESET;
			wi_q         <= '0;
			held_q       <= '0;
			ss_q         <= '0;
			cs_q         <= '0;
			prev_q       <= '0;
			prev_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_index == REG_WINDOW_SIZE)
				ws_q <= cfg_data[FILL_W-1:0];
			if (cfg_valid && cfg_index == REG_JUMP_THRESHOLD)
				thr_q <= cfg_data[THR_W-1:0];
			if (clear_win) begin
				held_q       <= '0;
				ss_q         <= '0;
				cs_q         <= '0;
				prev_q       <= '0;
				prev_valid_q <= 1'b0;
			end else if (cmd.acc_sub) begin
				held_q <= held_q - 1'b1;
				ss_q   <= ss_q - {{(SUM_W-16){sin_q[15]}}, sin_q};
				cs_q   <= cs_q - {{(SUM_W-16){cos_q[15]}}, cos_q};
			end else if (cmd.commit) begin
				wi_q         <= wi_next;
				held_q       <= held_q + 1'b1;
				prev_q       <= angle_q;
				prev_valid_q <= 1'b1;
			end else if (cmd.acc_add) begin
				ss_q <= ss_q + {{(SUM_W-16){sin_q[15]}}, sin_q};
				cs_q <= cs_q + {{(SUM_W-16){cos_q[15]}}, cos_q};
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= ring_q[old_idx];
		if (cmd.commit)
			ring_q[wi_q] <= angle_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			angle_q  <= in_data.angle;
			jumped_q <= 1'b0;
			mean_q   <= '0;
		end
		if (cmd.jump_eval)
			jumped_q <= jump;
		if (cmd.rot_start)
			flip_q <= rot_flip;
		if (cmd.rot_take) begin
			sin_q <= to_q15(c_y, flip_q);
			cos_q <= to_q15(c_x, flip_q);
		end
		if (cmd.mean_zero)
			mean_q <= '0;
		if (cmd.mean_take)
			mean_q <= zr[ZW-1:MEAN_SHIFT];
		if (cmd.load_out) begin
			out_q.mean_angle   <= mean_q;
			out_q.fill_count   <= held_q;
			out_q.window_full  <= full;
			out_q.jump_cleared <= jumped_q;
		end
	end

	always_comb begin
		status.evict       = !jump && full;
		status.sums_zero   = (held_q == '0) || (ss_q == '0 && cs_q == '0);
		status.cordic_done = c_done;
	end

	assign out_data = out_q;

endmodule

### design/wcm_ctrl.sv
// ----------------------------------------------------------------------------
// wcm_ctrl
// Sequencer: steps a sample through eviction, insertion and atan2, a clear
// straight to the result; owns the input stall and the result valid flag.
// ----------------------------------------------------------------------------
module wcm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_kind,
	input  logic                out_stall,
	input  wcm_pkg::dp_status_t status,
	output logic                in_stall,
	output logic                out_valid,
	output wcm_pkg::ctrl_cmd_t  cmd
);
	import wcm_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = (state_q != ST_IDLE);
		out_free = !out_valid_q || !out_stall;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = in_kind ? ST_OUT : ST_JUMP;
				end
			end
			ST_JUMP: begin
				cmd.jump_eval = 1'b1;
				state_d       = status.evict ? ST_OLD_GO : ST_NEW_GO;
			end
			ST_OLD_GO: begin
				cmd.rot_start = 1'b1;
				cmd.rot_old   = 1'b1;
				state_d       = ST_OLD_WAIT;
			end
			ST_OLD_WAIT: begin
				if (status.cordic_done) begin
					cmd.rot_take = 1'b1;
					state_d      = ST_OLD_ACC;
				end
			end
			ST_OLD_ACC: begin
				cmd.acc_sub = 1'b1;
				state_d     = ST_NEW_GO;
			end
			ST_NEW_GO: begin
				cmd.rot_start = 1'b1;
				cmd.commit    = 1'b1;
				state_d       = ST_NEW_WAIT;
			end
			ST_NEW_WAIT: begin
				if (status.cordic_done) begin
					cmd.rot_take = 1'b1;
					state_d      = ST_NEW_ACC;
				end
			end
			ST_NEW_ACC: begin
				cmd.acc_add = 1'b1;
				state_d     = ST_VEC_GO;
			end
			ST_VEC_GO: begin
				if (status.sums_zero) begin
					cmd.mean_zero = 1'b1;
					state_d       = ST_OUT;
				end else begin
					cmd.vec_start = 1'b1;
					state_d       = ST_VEC_WAIT;
				end
			end
			ST_VEC_WAIT: begin
				if (status.cordic_done) begin
					cmd.mean_take = 1'b1;
					state_d       = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

### design/windowed_circular_mean_top.sv
// Each sample or clear is carried through to its result before the next is taken;
// the input stalls meanwhile. When the sums cancel, atan2 is skipped; a clear goes
// straight to the result. The pace is set by the single shared 24-step CORDIC (one
// step a cycle), run per evicted sample, per new sample and for atan2.
// Reset: arst_n clears the window, sums, previous sample and handshake state.
// ----------------------------------------------------------------------------
// windowed_circular_mean_top
// Sliding-window circular mean of binary angles, controller and datapath.
// ----------------------------------------------------------------------------
module windowed_circular_mean_top #(
	parameter int WINDOW_DEPTH = wcm_pkg::DEF_WINDOW_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  wcm_pkg::in_item_t              in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output wcm_pkg::out_item_t             out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [wcm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wcm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import wcm_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;
	logic       cfg_write;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	wcm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_kind   (in_data.kind),
		.out_stall (out_stall),
		.status    (status),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	wcm_datapath #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_valid (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_data  (out_data)
	);

endmodule

### design/wcm_checker.sv
// ----------------------------------------------------------------------------
// wcm_checker
// Port-level checks on the windowed circular mean top level, bound to it.
// ----------------------------------------------------------------------------
module wcm_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  wcm_pkg::in_item_t              in_data,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  wcm_pkg::out_item_t             out_data
);
	import wcm_pkg::*;

	logic in_xfer;

	assign in_xfer = in_valid && !in_stall;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// one item in work at a time
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> in_stall)
		else $error("input not stalled after transfer");

	// a result only appears out of an item in work
	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without an item in work");

	// clear item answers with an empty window
	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && in_data.kind && !out_valid |-> ##2
			(out_valid && out_data.fill_count == '0 && out_data.mean_angle == '0 &&
			 !out_data.window_full && !out_data.jump_cleared))
		else $error("clear item result wrong");

endmodule

bind windowed_circular_mean_top wcm_checker u_wcm_checker (.*);
